FILE: src/didsc_pkg.sv
// types and constants shared by the device idle detect scanner
// no dependencies; used by every module of the block but the table memory
`timescale 1ns / 1ps

package didsc_pkg;

   // request modes
   localparam logic [1:0] MODE_TICK     = 2'd0;
   localparam logic [1:0] MODE_SETTINGS = 2'd1;
   localparam logic [1:0] MODE_BUSY     = 2'd2;

   // device idle kinds
   localparam logic [1:0] KIND_NORMAL = 2'd0;
   localparam logic [1:0] KIND_DISK   = 2'd1;

   // configuration register indexes
   localparam logic CSR_ON_BATTERY = 1'b0;
   localparam logic CSR_SPINDOWN   = 1'b1;

   localparam logic [31:0] IDLE_MAX = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [1:0]  mode;
      logic [3:0]  device_slot;
      logic        entry_enable;
      logic [1:0]  entry_kind;
      logic [31:0] battery_idle_time;
      logic [31:0] ac_idle_time;
      logic [2:0]  target_state;
      logic [15:0] busy_refs;
      logic [15:0] busy_ticks;
   } req_type;

   typedef struct packed {
      logic [3:0] device_index;
      logic [2:0] pwr_state;
      logic       unknown_kind_fault;
      logic       last;
   } rsp_type;

   // per-entry settings word
   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] battery_thr;
      logic [31:0] ac_thr;
      logic [2:0]  target;
   } entry_cfg_type;

   // per-entry busy status word
   typedef struct packed {
      logic [15:0] refs;
      logic [15:0] brief;
   } busy_cnt_type;

   typedef struct packed {
      logic [15:0] new_brief;
      logic        brief_wr;
      logic [31:0] new_idle;
      logic        evt_valid;
      logic        fault;
      logic [2:0]  pwr_state;
   } step_out_type;

   typedef struct packed {
      logic    push;
      logic    flush;
      rsp_type item;
   } qctl_type;

   typedef struct packed {
      logic ready;
      logic pend_valid;
   } qstat_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_READ  = 4'b0010,
      ST_EXEC  = 4'b0100,
      ST_FLUSH = 4'b1000
   } scan_state_type;

endpackage

FILE: src/didsc_entry_ram.sv
// one-write one-read table memory with registered read data
// no dependencies; instantiated by the scanner top level
`timescale 1ns / 1ps

module didsc_entry_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/didsc_step_unit.sv
// shared per-entry update: busy handling, idle count advance, threshold compare
// depends on didsc_pkg
`timescale 1ns / 1ps

module didsc_step_unit (
   input  didsc_pkg::busy_cnt_type  busy,
   input  logic [31:0]              idle_ticks,
   input  didsc_pkg::entry_cfg_type cfg,
   input  logic                     on_battery,
   input  logic [31:0]              spindown_timeout,
   output didsc_pkg::step_out_type  result
);

   logic        advanced;
   logic [31:0] thr;
   logic [31:0] incremented;

   assign incremented = idle_ticks + 32'd1;

   always_comb begin
      advanced = 1'b0;
      thr = 32'd0;
      result.new_brief = busy.brief;
      result.brief_wr = 1'b0;
      result.new_idle = idle_ticks;
      result.evt_valid = 1'b0;
      result.fault = 1'b0;
      result.pwr_state = cfg.target;
      priority if (busy.refs != 16'd0) begin
         result.new_idle = 32'd0;
      end else if (busy.brief != 16'd0) begin
         result.new_brief = busy.brief - 16'd1;
         result.brief_wr = 1'b1;
         result.new_idle = 32'd0;
      end else begin
         advanced = (idle_ticks != didsc_pkg::IDLE_MAX);
         if (advanced) begin
            result.new_idle = incremented;
         end
         unique case (cfg.kind)
            didsc_pkg::KIND_NORMAL: begin
               thr = on_battery ? cfg.battery_thr : cfg.ac_thr;
            end
            didsc_pkg::KIND_DISK: begin
               thr = spindown_timeout;
            end
            default: begin
               // unknown kind: report a fault, no power request
               result.fault = 1'b1;
               result.pwr_state = 3'd0;
               result.evt_valid = 1'b1;
            end
         endcase
         if (!result.fault && advanced && (thr != 32'd0) && (result.new_idle == thr)) begin
            result.evt_valid = 1'b1;
         end
      end
   end

endmodule

FILE: src/didsc_result_queue.sv
// result holding stage and output register; marks the last result of a tick
// depends on didsc_pkg
`timescale 1ns / 1ps

module didsc_result_queue (
   input  logic                clock,
   input  logic                reset,
   input  didsc_pkg::qctl_type ctl,
   output didsc_pkg::qstat_type status,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output didsc_pkg::rsp_type  rsp_data
);

   logic               pend_v_ff, pend_v_in;
   didsc_pkg::rsp_type pend_ff, pend_in;
   logic               out_v_ff, out_v_in;
   didsc_pkg::rsp_type out_ff, out_in;
   logic               out_free;

   assign out_free = !out_v_ff || !rsp_stall;

   always_comb begin
      pend_v_in = pend_v_ff;
      pend_in = pend_ff;
      out_v_in = out_v_ff && rsp_stall;
      out_in = out_ff;
      if (ctl.push && (!pend_v_ff || out_free)) begin
         // held result moves out once a newer one shows it is not last
         if (pend_v_ff) begin
            out_v_in = 1'b1;
            out_in = pend_ff;
            out_in.last = 1'b0;
         end
         pend_v_in = 1'b1;
         pend_in = ctl.item;
      end else if (ctl.flush && pend_v_ff && out_free) begin
         out_v_in = 1'b1;
         out_in = pend_ff;
         out_in.last = 1'b1;
         pend_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         pend_v_ff <= pend_v_in;
         out_v_ff <= out_v_in;
      end
      pend_ff <= pend_in;
      out_ff <= out_in;
   end

   assign status.ready = !pend_v_ff || out_free;
   assign status.pend_valid = pend_v_ff;
   assign rsp_valid = out_v_ff;
   assign rsp_data = out_ff;

endmodule

FILE: src/device_idle_detect_scanner_top.sv
// device idle detect scanner, top level: sequencer, valid bits, registers
// depends on didsc_pkg, didsc_entry_ram, didsc_step_unit, didsc_result_queue
`timescale 1ns / 1ps

// usage
//  request channel (req_valid / req_stall / req_data): mode 1 loads an entry's
//  settings, mode 2 its busy status, mode 0 runs a tick scan; mode 3 and writes
//  to a slot at or above NUM_DEVICES are dropped
//  a write request gives no result
//  a tick walks the table in slot order: an unregistered entry is skipped in
//  ST_READ, a registered one passes ST_READ (table read), then ST_EXEC (the
//  shared step unit and write-back), and the walk closes in ST_FLUSH; the
//  registered table read is not overlapped with the step
//  req_stall stays high for the whole scan
//  result channel (rsp_valid / rsp_stall / rsp_data): one result per power
//  request or unknown-kind fault, last set on the final one; a quiet tick
//  gives none. a result is held back one slot so that last can be known
//  a stalled receiver pauses the scan once the output register and the
//  holding stage are full; nothing is lost
//  csr port: index 0 on_battery, index 1 spindown_timeout; write only while idle
//  reset: all entries unregistered, busy and idle counters read as zero,
//  registers cleared; no clearing pass is needed

module device_idle_detect_scanner_top #(
   parameter int NUM_DEVICES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  didsc_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output didsc_pkg::rsp_type rsp_data,
   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  logic [31:0]        csr_write_data
);

   localparam int IDX_W = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
   localparam int CFG_W = $bits(didsc_pkg::entry_cfg_type);
   localparam int BUSY_W = $bits(didsc_pkg::busy_cnt_type);

   // sequencer state
   didsc_pkg::scan_state_type state_ff, state_in;
   logic [IDX_W-1:0]          scan_idx_ff, scan_idx_in;
   logic                      scan_at_end;

   // per-entry flags: registered, busy word written, idle word written
   logic [NUM_DEVICES-1:0] entry_valid_ff, entry_valid_in;
   logic [NUM_DEVICES-1:0] busy_init_ff, busy_init_in;
   logic [NUM_DEVICES-1:0] idle_init_ff, idle_init_in;
   logic                   busy_init_rd_ff, busy_init_rd_in;
   logic                   idle_init_rd_ff, idle_init_rd_in;

   // configuration registers
   logic        on_battery_ff, on_battery_in;
   logic [31:0] spindown_ff, spindown_in;

   // request decode
   logic             req_fire;
   logic             slot_ok;
   logic [IDX_W-1:0] slot_addr;
   logic             settings_wr;
   logic             busy_req_wr;

   // table ports
   logic                     cfg_wr_en;
   didsc_pkg::entry_cfg_type cfg_wr_data;
   didsc_pkg::entry_cfg_type cfg_rd_data;
   logic                     busy_wr_en;
   logic [IDX_W-1:0]         busy_wr_addr;
   didsc_pkg::busy_cnt_type  busy_wr_data;
   didsc_pkg::busy_cnt_type  busy_rd_data;
   didsc_pkg::busy_cnt_type  busy_eff;
   logic                     idle_wr_en;
   logic [31:0]              idle_rd_data;
   logic [31:0]              idle_eff;
   logic                     rd_en;

   // step unit and result queue
   didsc_pkg::step_out_type step;
   logic                    exec_adv;
   logic [31:0]             scan_idx_wide;
   didsc_pkg::qctl_type     q_ctl;
   didsc_pkg::qstat_type    q_stat;

   assign req_stall = (state_ff != didsc_pkg::ST_IDLE);
   assign req_fire = req_valid && !req_stall;
   assign slot_ok = (32'(req_data.device_slot) < NUM_DEVICES);
   assign slot_addr = IDX_W'(req_data.device_slot);
   assign settings_wr = req_fire && (req_data.mode == didsc_pkg::MODE_SETTINGS) && slot_ok;
   assign busy_req_wr = req_fire && (req_data.mode == didsc_pkg::MODE_BUSY) && slot_ok;

   assign scan_at_end = (scan_idx_ff == IDX_W'(NUM_DEVICES - 1));
   assign scan_idx_wide = 32'(scan_idx_ff);

   // only registered entries are read; the rest are skipped without a read
   assign rd_en = (state_ff == didsc_pkg::ST_READ) && entry_valid_ff[scan_idx_ff];

   // counters never written since reset read as zero
   assign busy_eff = busy_init_rd_ff ? busy_rd_data : '0;
   assign idle_eff = idle_init_rd_ff ? idle_rd_data : 32'd0;

   // an entry with an event waits until the result queue has room
   assign exec_adv = (state_ff == didsc_pkg::ST_EXEC) && (!step.evt_valid || q_stat.ready);

   assign cfg_wr_en = settings_wr;
   assign cfg_wr_data.kind = req_data.entry_kind;
   assign cfg_wr_data.battery_thr = req_data.battery_idle_time;
   assign cfg_wr_data.ac_thr = req_data.ac_idle_time;
   assign cfg_wr_data.target = req_data.target_state;

   always_comb begin
      busy_wr_en = busy_req_wr;
      busy_wr_addr = slot_addr;
      busy_wr_data.refs = req_data.busy_refs;
      busy_wr_data.brief = req_data.busy_ticks;
      if (state_ff == didsc_pkg::ST_EXEC) begin
         // brief busy tick consumed by the scan
         busy_wr_en = exec_adv && step.brief_wr;
         busy_wr_addr = scan_idx_ff;
         busy_wr_data.refs = busy_eff.refs;
         busy_wr_data.brief = step.new_brief;
      end
   end

   assign idle_wr_en = exec_adv;

   // result queue control
   assign q_ctl.push = (state_ff == didsc_pkg::ST_EXEC) && step.evt_valid;
   assign q_ctl.flush = (state_ff == didsc_pkg::ST_FLUSH);
   assign q_ctl.item.device_index = scan_idx_wide[3:0];
   assign q_ctl.item.pwr_state = step.pwr_state;
   assign q_ctl.item.unknown_kind_fault = step.fault;
   assign q_ctl.item.last = 1'b0;

   // sequencer
   always_comb begin
      state_in = state_ff;
      scan_idx_in = scan_idx_ff;
      unique case (state_ff)
         didsc_pkg::ST_IDLE: begin
            if (req_fire && (req_data.mode == didsc_pkg::MODE_TICK)) begin
               state_in = didsc_pkg::ST_READ;
               scan_idx_in = '0;
            end
         end
         didsc_pkg::ST_READ: begin
            if (rd_en) begin
               state_in = didsc_pkg::ST_EXEC;
            end else if (scan_at_end) begin
               state_in = didsc_pkg::ST_FLUSH;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
         didsc_pkg::ST_EXEC: begin
            if (exec_adv) begin
               if (scan_at_end) begin
                  state_in = didsc_pkg::ST_FLUSH;
               end else begin
                  state_in = didsc_pkg::ST_READ;
                  scan_idx_in = scan_idx_ff + 1'b1;
               end
            end
         end
         didsc_pkg::ST_FLUSH: begin
            // held result leaves with last set, or there was none
            if (!q_stat.pend_valid || q_stat.ready) begin
               state_in = didsc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = didsc_pkg::ST_IDLE;
         end
      endcase
   end

   // per-entry flags and read-side init flags
   always_comb begin
      entry_valid_in = entry_valid_ff;
      busy_init_in = busy_init_ff;
      idle_init_in = idle_init_ff;
      busy_init_rd_in = busy_init_rd_ff;
      idle_init_rd_in = idle_init_rd_ff;
      if (settings_wr) begin
         entry_valid_in[slot_addr] = req_data.entry_enable;
      end
      if (busy_wr_en) begin
         busy_init_in[busy_wr_addr] = 1'b1;
      end
      if (idle_wr_en) begin
         idle_init_in[scan_idx_ff] = 1'b1;
      end
      if (rd_en) begin
         busy_init_rd_in = busy_init_ff[scan_idx_ff];
         idle_init_rd_in = idle_init_ff[scan_idx_ff];
      end
   end

   // configuration registers
   always_comb begin
      on_battery_in = on_battery_ff;
      spindown_in = spindown_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            didsc_pkg::CSR_ON_BATTERY: on_battery_in = csr_write_data[0];
            didsc_pkg::CSR_SPINDOWN:   spindown_in = csr_write_data;
            default:                   on_battery_in = on_battery_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= didsc_pkg::ST_IDLE;
         scan_idx_ff <= '0;
         entry_valid_ff <= '0;
         busy_init_ff <= '0;
         idle_init_ff <= '0;
         busy_init_rd_ff <= 1'b0;
         idle_init_rd_ff <= 1'b0;
         on_battery_ff <= 1'b0;
         spindown_ff <= 32'd0;
      end else begin
         state_ff <= state_in;
         scan_idx_ff <= scan_idx_in;
         entry_valid_ff <= entry_valid_in;
         busy_init_ff <= busy_init_in;
         idle_init_ff <= idle_init_in;
         busy_init_rd_ff <= busy_init_rd_in;
         idle_init_rd_ff <= idle_init_rd_in;
         on_battery_ff <= on_battery_in;
         spindown_ff <= spindown_in;
      end
   end

   // entry settings table
   didsc_entry_ram #(
      .DEPTH  (NUM_DEVICES),
      .WIDTH  (CFG_W),
      .ADDR_W (IDX_W)
   ) u_cfg_ram (
      .clock   (clock),
      .wr_en   (cfg_wr_en),
      .wr_addr (slot_addr),
      .wr_data (cfg_wr_data),
      .rd_en   (rd_en),
      .rd_addr (scan_idx_ff),
      .rd_data (cfg_rd_data)
   );

   // busy status table
   didsc_entry_ram #(
      .DEPTH  (NUM_DEVICES),
      .WIDTH  (BUSY_W),
      .ADDR_W (IDX_W)
   ) u_busy_ram (
      .clock   (clock),
      .wr_en   (busy_wr_en),
      .wr_addr (busy_wr_addr),
      .wr_data (busy_wr_data),
      .rd_en   (rd_en),
      .rd_addr (scan_idx_ff),
      .rd_data (busy_rd_data)
   );

   // idle tick counters
   didsc_entry_ram #(
      .DEPTH  (NUM_DEVICES),
      .WIDTH  (32),
      .ADDR_W (IDX_W)
   ) u_idle_ram (
      .clock   (clock),
      .wr_en   (idle_wr_en),
      .wr_addr (scan_idx_ff),
      .wr_data (step.new_idle),
      .rd_en   (rd_en),
      .rd_addr (scan_idx_ff),
      .rd_data (idle_rd_data)
   );

   didsc_step_unit u_step (
      .busy             (busy_eff),
      .idle_ticks       (idle_eff),
      .cfg              (cfg_rd_data),
      .on_battery       (on_battery_ff),
      .spindown_timeout (spindown_ff),
      .result           (step)
   );

   didsc_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .ctl       (q_ctl),
      .status    (q_stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // scan index stays inside the table while the scan is active
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == didsc_pkg::ST_READ || state_ff == didsc_pkg::ST_EXEC)
      |-> (scan_idx_wide < NUM_DEVICES))
      else $error("scan index beyond table");

   // an accepted tick starts the walk at slot zero
   a_tick_start: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.mode == didsc_pkg::MODE_TICK)
      |=> (state_ff == didsc_pkg::ST_READ && scan_idx_ff == '0))
      else $error("tick did not start a scan");

   // no result is left held once the scanner is idle again
   a_no_held_when_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == didsc_pkg::ST_IDLE) |-> !q_stat.pend_valid)
      else $error("result held after scan end");

   // a fault result never carries a power request
   a_fault_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.unknown_kind_fault) |-> (rsp_data.pwr_state == 3'd0))
      else $error("fault result with power state");

endmodule
